>>> rtl/pdl_pkg.sv
package pdl_pkg;

  localparam int RESOURCES  = 64;
  localparam int MAX_LEVELS = 64;
  localparam int LANES      = 8;
  localparam int LANE_W     = (RESOURCES + LANES - 1) / LANES;

  localparam int MASK_W  = 64;
  localparam int LEVEL_W = 6;
  localparam int COUNT_W = 7;
  localparam int WL_W    = 7;

  localparam int TOP_LEVEL = (MAX_LEVELS - 1 > 63) ? 63 : MAX_LEVELS - 1;

  typedef logic [WL_W-1:0]      wlevel_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [RESOURCES-1:0] res_mask_t;

  typedef struct packed {
    logic    prod;
    wlevel_t best;
  } lane_res_t;

  typedef struct packed {
    logic      new_graph;
    wlevel_t   val;
    res_mask_t write;
  } fwd_t;

  typedef struct packed {
    level_t  level;
    logic    prod;
    wlevel_t wval;
  } merge_res_t;

endpackage

>>> rtl/pdl_pass_if.sv
interface pdl_pass_if;
  import pdl_pkg::*;

  logic              valid;
  logic              ready;
  logic              new_graph;
  logic [MASK_W-1:0] read_mask;
  logic [MASK_W-1:0] write_mask;

  modport source (output valid, new_graph, read_mask, write_mask, input ready);
  modport sink (input valid, new_graph, read_mask, write_mask, output ready);
endinterface

>>> rtl/pdl_level_if.sv
interface pdl_level_if;
  import pdl_pkg::*;

  logic         valid;
  logic         ready;
  level_t       level;
  logic         has_producer;
  count_t       level_count;

  modport source (output valid, level, has_producer, level_count, input ready);
  modport sink (input valid, level, has_producer, level_count, output ready);
endinterface

>>> rtl/pass_dependency_leveler_core.sv
// Assigns each graph pass its dependency level, one pass per cycle unless stalled.
// A pass transfers in, its read bits are checked against the kept writer levels by
// eight parallel lanes in the input cycle, and the lane results are registered, then
// merged, saturated and committed to the writer table once the output register is
// free or being read; the result then sits in that output register. The commit of
// the previous pass is forwarded into the merge, which keeps the one-cycle rate for
// dependent passes. new_graph on a pass clears all kept levels before that pass.
module pass_dependency_leveler_core
  import pdl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pdl_pass_if.sink    pass_in,
  pdl_level_if.source level_out
);

  wlevel_t    tbl [RESOURCES];
  level_t     highest;

  logic       rd_l [LANES][LANE_W];
  wlevel_t    wl_l [LANES][LANE_W];
  lane_res_t  lane_res [LANES];

  logic       b_valid;
  logic       b_new_graph;
  logic       b_fwd;
  lane_res_t  b_lanes [LANES];
  res_mask_t  b_read;
  res_mask_t  b_write;

  fwd_t       fwd;
  merge_res_t mres;

  logic       out_valid;
  level_t     out_level;
  logic       out_prod;
  count_t     out_count;

  logic       b_adv;
  logic       commit;
  logic       take;
  level_t     high_base;
  level_t     highest_next;

  genvar gl, gj;
  generate
    for (gl = 0; gl < LANES; gl++) begin : g_lane
      for (gj = 0; gj < LANE_W; gj++) begin : g_bit
        if (gl * LANE_W + gj < RESOURCES) begin : g_used
          assign rd_l[gl][gj] = pass_in.read_mask[gl * LANE_W + gj];
          assign wl_l[gl][gj] = tbl[gl * LANE_W + gj];
        end else begin : g_pad
          assign rd_l[gl][gj] = 1'b0;
          assign wl_l[gl][gj] = '0;
        end
      end
      pdl_lane u_lane (
        .rd  (rd_l[gl]),
        .wl  (wl_l[gl]),
        .res (lane_res[gl])
      );
    end
  endgenerate

  pdl_merge u_merge (
    .lanes     (b_lanes),
    .new_graph (b_new_graph),
    .use_fwd   (b_fwd),
    .fwd       (fwd),
    .read      (b_read),
    .res       (mres)
  );

  assign b_adv   = !out_valid || level_out.ready;
  assign commit  = b_valid && b_adv;
  assign pass_in.ready = !rst && (!b_valid || b_adv);
  assign take    = pass_in.valid && pass_in.ready;

  assign high_base    = b_new_graph ? '0 : highest;
  assign highest_next = (mres.level > high_base) ? mres.level : high_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_fwd   <= 1'b0;
    end else begin
      if (take) begin
        b_valid <= 1'b1;
        b_fwd   <= commit;
      end else if (commit) begin
        b_valid <= 1'b0;
        b_fwd   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_new_graph <= pass_in.new_graph;
      b_lanes     <= lane_res;
      b_read      <= pass_in.read_mask[RESOURCES-1:0];
      b_write     <= pass_in.write_mask[RESOURCES-1:0];
    end
    if (commit) begin
      fwd.new_graph <= b_new_graph;
      fwd.val       <= mres.wval;
      fwd.write     <= b_write;
      out_level     <= mres.level;
      out_prod      <= mres.prod;
      out_count     <= {1'b0, highest_next} + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest <= '0;
      for (int r = 0; r < RESOURCES; r++) begin
        tbl[r] <= '0;
      end
    end else if (commit) begin
      highest <= highest_next;
      for (int r = 0; r < RESOURCES; r++) begin
        if (b_write[r] && ((b_new_graph ? wlevel_t'(0) : tbl[r]) < mres.wval)) begin
          tbl[r] <= mres.wval;
        end else if (b_new_graph) begin
          tbl[r] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (level_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign level_out.valid        = out_valid;
  assign level_out.level        = out_level;
  assign level_out.has_producer = out_prod;
  assign level_out.level_count  = out_count;

endmodule

>>> rtl/pdl_lane.sv
module pdl_lane
  import pdl_pkg::*;
(
  input  logic      rd  [LANE_W],
  input  wlevel_t   wl  [LANE_W],
  output lane_res_t res
);

  always_comb begin
    res = '0;
    for (int j = 0; j < LANE_W; j++) begin
      if (rd[j] && (wl[j] != '0)) begin
        res.prod = 1'b1;
        if (wl[j] > res.best) begin
          res.best = wl[j];
        end
      end
    end
  end

endmodule

>>> rtl/pdl_merge.sv
module pdl_merge
  import pdl_pkg::*;
(
  input  lane_res_t  lanes [LANES],
  input  logic       new_graph,
  input  logic       use_fwd,
  input  fwd_t       fwd,
  input  res_mask_t  read,
  output merge_res_t res
);

  wlevel_t best;
  logic    prod;
  logic    hit;

  assign hit = use_fwd && ((read & fwd.write) != '0);

  always_comb begin
    best = '0;
    prod = 1'b0;
    if (!new_graph) begin
      if (!(use_fwd && fwd.new_graph)) begin
        for (int l = 0; l < LANES; l++) begin
          prod = prod | lanes[l].prod;
          if (lanes[l].best > best) begin
            best = lanes[l].best;
          end
        end
      end
      if (hit) begin
        prod = 1'b1;
        if (fwd.val > best) begin
          best = fwd.val;
        end
      end
    end
    res.prod = prod;
    if (best > wlevel_t'(TOP_LEVEL)) begin
      res.level = level_t'(TOP_LEVEL);
    end else begin
      res.level = best[LEVEL_W-1:0];
    end
    res.wval = {1'b0, res.level} + wlevel_t'(1);
  end

endmodule

>>> dv/tb_top.sv
module tb_top
  import pdl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PASSES = 900;
  localparam int QUIET_PASSES  = 150;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int DIRECTED_ROWS = 18;

  localparam logic [MASK_W-1:0] ALL_ONES = {MASK_W{1'b1}};
  localparam logic [MASK_W-1:0] NO_BITS  = '0;

  typedef struct packed {
    level_t level;
    logic   has_producer;
    count_t level_count;
  } level_res_t;

  typedef struct packed {
    logic              new_graph;
    logic [MASK_W-1:0] read_mask;
    logic [MASK_W-1:0] write_mask;
    logic              typed;
    level_t            level;
    logic              has_producer;
    count_t            level_count;
  } pass_row_t;

  logic clk;
  logic rst;

  pdl_pass_if  pass_ch();
  pdl_level_if level_ch();

  pass_dependency_leveler_core dut (
    .clk       (clk),
    .rst       (rst),
    .pass_in   (pass_ch),
    .level_out (level_ch)
  );

  wlevel_t    kept_writer_level [RESOURCES];
  level_t     kept_highest;
  level_res_t pending_levels [$];
  int         errors = 0;
  int         cycles = 0;
  bit         idle_on;
  int         ready_hold = 0;

  pass_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{1'b1, ALL_ONES, NO_BITS, 1'b1, 6'd0, 1'b0, 7'd1},
    '{1'b0, NO_BITS, ALL_ONES, 1'b1, 6'd0, 1'b0, 7'd1},
    '{1'b0, ALL_ONES, ALL_ONES, 1'b1, 6'd1, 1'b1, 7'd2},
    '{1'b0, 64'h8000_0000_0000_0000, 64'h1, 1'b1, 6'd2, 1'b1, 7'd3},
    '{1'b0, 64'h1, NO_BITS, 1'b1, 6'd3, 1'b1, 7'd4},
    '{1'b1, ALL_ONES, NO_BITS, 1'b1, 6'd0, 1'b0, 7'd1},
    '{1'b0, NO_BITS, 64'h20, 1'b1, 6'd0, 1'b0, 7'd1},
    '{1'b0, 64'h20, 64'h40, 1'b1, 6'd1, 1'b1, 7'd2},
    '{1'b0, 64'h40, 64'h20, 1'b1, 6'd2, 1'b1, 7'd3},
    '{1'b0, NO_BITS, 64'h20, 1'b1, 6'd0, 1'b0, 7'd3},
    '{1'b0, 64'h20, NO_BITS, 1'b1, 6'd3, 1'b1, 7'd4},
    '{1'b1, ALL_ONES, ALL_ONES, 1'b1, 6'd0, 1'b0, 7'd1},
    '{1'b0, NO_BITS, NO_BITS, 1'b1, 6'd0, 1'b0, 7'd1},
    '{1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 6'd0, 1'b0, 7'd0},
    '{1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 6'd0, 1'b0, 7'd0},
    '{1'b0, 64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 6'd0, 1'b0, 7'd0},
    '{1'b1, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 1'b0, 6'd0, 1'b0, 7'd0},
    '{1'b0, 64'h1234_5678_9ABC_DEF0, 64'hFEDC_BA98_7654_3210, 1'b0, 6'd0, 1'b0, 7'd0}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic level_res_t compute_pass_level(input logic new_graph,
                                                    input logic [MASK_W-1:0] read_mask,
                                                    input logic [MASK_W-1:0] write_mask);
    level_res_t res;
    int         best;
    logic       producer;
    level_t     lvl;
    best = 0;
    producer = 1'b0;
    if (new_graph) begin
      for (int r = 0; r < RESOURCES; r++) kept_writer_level[r] = '0;
      kept_highest = '0;
    end
    for (int r = 0; r < RESOURCES && r < MASK_W; r++) begin
      if (read_mask[r] && kept_writer_level[r] != '0) begin
        producer = 1'b1;
        if (int'(kept_writer_level[r]) > best) best = int'(kept_writer_level[r]);
      end
    end
    lvl = (best > TOP_LEVEL) ? level_t'(TOP_LEVEL) : level_t'(best);
    for (int r = 0; r < RESOURCES && r < MASK_W; r++) begin
      if (write_mask[r] && int'(kept_writer_level[r]) < int'(lvl) + 1)
        kept_writer_level[r] = wlevel_t'(int'(lvl) + 1);
    end
    if (lvl > kept_highest) kept_highest = lvl;
    res.level = lvl;
    res.has_producer = producer;
    res.level_count = count_t'(int'(kept_highest) + 1);
    return res;
  endfunction

  task automatic send_pass(input logic new_graph, input logic [MASK_W-1:0] read_mask,
                           input logic [MASK_W-1:0] write_mask, input logic typed,
                           input level_res_t typed_res);
    level_res_t predicted;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pass_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    pass_ch.valid      <= 1'b1;
    pass_ch.new_graph  <= new_graph;
    pass_ch.read_mask  <= read_mask;
    pass_ch.write_mask <= write_mask;
    do @(posedge clk); while (!pass_ch.ready);
    predicted = compute_pass_level(new_graph, read_mask, write_mask);
    if (typed) predicted = typed_res;
    pending_levels.insert(pending_levels.size(), predicted);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      level_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      level_ch.ready <= 1'b0;
      ready_hold <= $urandom_range(0, 4);
    end else begin
      level_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    level_res_t want;
    if (!rst && level_ch.valid && level_ch.ready) begin
      if (pending_levels.size() == 0) begin
        errors++;
        $error("result transfer with no pass outstanding");
      end else begin
        want = pending_levels.pop_front();
        if (level_ch.level !== want.level) begin
          errors++;
          $error("level: expected %0d, actual %0d", want.level, level_ch.level);
        end
        if (level_ch.has_producer !== want.has_producer) begin
          errors++;
          $error("has_producer: expected %0d, actual %0d", want.has_producer,
                 level_ch.has_producer);
        end
        if (level_ch.level_count !== want.level_count) begin
          errors++;
          $error("level_count: expected %0d, actual %0d", want.level_count,
                 level_ch.level_count);
        end
      end
    end
  end

  initial begin
    logic [MASK_W-1:0] rd;
    logic [MASK_W-1:0] wr;
    logic              ng;
    int                sent;
    int                graph_len;
    int                pool [4];
    int                mode;
    level_res_t        typed_res;

    idle_on = 1'b1;
    for (int r = 0; r < RESOURCES; r++) kept_writer_level[r] = '0;
    kept_highest = '0;

    rst <= 1'b1;
    pass_ch.valid      <= 1'b0;
    pass_ch.new_graph  <= 1'b0;
    pass_ch.read_mask  <= '0;
    pass_ch.write_mask <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      typed_res.level        = directed_rows[i].level;
      typed_res.has_producer = directed_rows[i].has_producer;
      typed_res.level_count  = directed_rows[i].level_count;
      send_pass(directed_rows[i].new_graph, directed_rows[i].read_mask,
                directed_rows[i].write_mask, directed_rows[i].typed, typed_res);
    end

    // Graphs are mostly dependency chains over a few resources, so that levels climb
    // far enough to saturate; the rest is sparse, dense and extreme noise.
    sent = 0;
    while (sent < RANDOM_PASSES) begin
      graph_len = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 120)
                                              : $urandom_range(1, 40);
      foreach (pool[k]) pool[k] = $urandom_range(0, RESOURCES - 1);
      for (int p = 0; p < graph_len && sent < RANDOM_PASSES; p++) begin
        if (sent >= RANDOM_PASSES - QUIET_PASSES) idle_on = 1'b0;
        ng = (p == 0) || ($urandom_range(0, 49) == 0);
        mode = $urandom_range(0, 9);
        rd = '0;
        wr = '0;
        if (mode <= 5) begin
          rd[pool[$urandom_range(0, 3)]] = 1'b1;
          if ($urandom_range(0, 3) == 0) rd[pool[$urandom_range(0, 3)]] = 1'b1;
          wr[pool[$urandom_range(0, 3)]] = 1'b1;
          if ($urandom_range(0, 1) == 0) wr = wr | rd;
          if ($urandom_range(0, 7) == 0) wr[$urandom_range(0, MASK_W - 1)] = 1'b1;
        end else if (mode <= 7) begin
          rd[$urandom_range(0, MASK_W - 1)] = 1'b1;
          wr[$urandom_range(0, MASK_W - 1)] = 1'b1;
        end else if (mode == 8) begin
          rd = {$urandom, $urandom};
          wr = {$urandom, $urandom};
        end else begin
          rd = $urandom_range(0, 1) ? ALL_ONES : NO_BITS;
          wr = $urandom_range(0, 1) ? ALL_ONES : NO_BITS;
        end
        send_pass(ng, rd, wr, 1'b0, typed_res);
        sent++;
      end
    end

    pass_ch.valid <= 1'b0;
    wait (pending_levels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_levels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
